/* src/tcc_pkg.sv */
// Shared types and constants for the text console character writer.
package tcc_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int DATA_W = 16;
  localparam int FUNC_W = 2;
  localparam int ATTR_W = 8;

  localparam logic [DATA_W-1:0] BLANK_CELL  = 16'h0F20;
  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
  localparam logic [2:0]        ADDR_ATTR   = 3'd0;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7F;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PRINT,
    OP_BS,
    OP_TAB,
    OP_CR,
    OP_LF,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

/* src/text_console_char_writer_top.sv */
// Top level of the text console character writer: config register and datapath.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    tuser func, tdata char_code, cell_index
//   m_*      out  m_tvalid/m_tready    tdata cursor_pos, read_data, scrolled
//   apb      in   psel/penable/pwrite  text_attribute at byte address 0
//
// Put, no-op and out-of-range read requests go from idle to the response state; an in-range
// read passes through a read-data state first (memory read port is registered). Clear and
// scroll sweep every cell, one cell per cycle through the single write port, a scroll with
// a drain state after its sweep. After reset a clearing pass runs with s_tready low.
// A two-entry queue lets the front accept requests while the back is busy or
// the result register is held by m_tready.
module text_console_char_writer_top
  import tcc_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [10:0] cursor_pos, [26:11] read_data, [27] scrolled
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ATTR_W-1:0] attr;
  logic              push;
  cmd_t              push_data;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  cmd_t              q_data;
  back_stat_t        stat;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ATTR) ? {24'b0, attr} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_ATTR) begin
      attr <= pwdata[ATTR_W-1:0];
    end
  end

  tcc_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .stat      (stat),
    .push      (push),
    .push_data (push_data)
  );

  tcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  tcc_back #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .attr     (attr),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* src/tcc_front.sv */
// Front end: takes requests from the input stream and decodes them into commands.
module tcc_front
  import tcc_pkg::*;
(
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index
  input  logic [1:0] s_tuser,    // [1:0] func
  input  logic       q_full,
  input  back_stat_t stat,
  output logic       push,
  output cmd_t       push_data
);

  logic [CHAR_W-1:0] ch;

  assign ch       = s_tdata[CHAR_W-1:0];
  assign s_tready = !q_full && !stat.init_busy;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_data.ch  = ch;
    push_data.idx = s_tdata[CHAR_W +: IDX_W];
    push_data.op  = OP_NOP;
    case (s_tuser)
      FUNC_PUT: begin
        case (ch)
          CH_BS:   push_data.op = OP_BS;
          CH_TAB:  push_data.op = OP_TAB;
          CH_CR:   push_data.op = OP_CR;
          CH_LF:   push_data.op = OP_LF;
          default: begin
            if (ch inside {[PRINT_LO:PRINT_HI]}) push_data.op = OP_PRINT;
          end
        endcase
      end
      FUNC_CLEAR: push_data.op = OP_CLEAR;
      FUNC_READ:  push_data.op = OP_READ;
      default:    push_data.op = OP_NOP;
    endcase
  end

endmodule

/* src/tcc_queue.sv */
// Short command queue between the front end and the back end.
module tcc_queue
  import tcc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_data
);

  localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign full      = (count == CNTW'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* src/tcc_back.sv */
// Back end: screen memory, cursor, scroll and clear sweeps, result register.
module tcc_back
  import tcc_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ATTR_W-1:0] attr,
  input  logic              q_valid,
  input  cmd_t              q_data,
  output logic              q_pop,
  output back_stat_t        stat,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata   // [10:0] cursor_pos, [26:11] read_data, [27] scrolled
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int XW    = $clog2(COLUMNS + TAB_WIDTH);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] SHIFT_END = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_CLEAR  = 7'b0000100,
    S_RDATA  = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_SDRAIN = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic [AW-1:0]     sidx, sidx_next;
  logic [CW-1:0]     col, col_next;
  logic [RW-1:0]     row, row_next;
  logic [DATA_W-1:0] res_data, res_data_next;
  logic              res_scroll, res_scroll_next;

  logic [DATA_W-1:0] mem [CELLS];
  logic [DATA_W-1:0] rdata;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;

  // scroll write stage, writing in the cycle after its read
  logic              wp_valid;
  logic [AW-1:0]     wp_addr;
  logic              wp_blank;

  logic [XW-1:0]     tab_tbl [COLUMNS];
  logic [AW-1:0]     pos;
  logic [AW-1:0]     idx_addr;
  logic              idx_ok;
  logic [XW-1:0]     col_n;
  logic              row_inc;
  logic              load_out;

  logic [POS_W-1:0]  out_pos;
  logic [DATA_W-1:0] out_data;
  logic              out_scr;

  for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
    localparam int TabNext = (g / TAB_WIDTH + 1) * TAB_WIDTH;
    assign tab_tbl[g] = XW'(TabNext);
  end

  assign pos      = AW'(row) * COLS_A + AW'(col);
  assign idx_addr = AW'(q_data.idx);
  assign idx_ok   = (32'(q_data.idx) < 32'(CELLS));
  assign stat.init_busy = (state == S_INIT);

  always_comb begin
    state_next      = state;
    sidx_next       = sidx;
    col_next        = col;
    row_next        = row;
    res_data_next   = res_data;
    res_scroll_next = res_scroll;
    we              = 1'b0;
    waddr           = sidx;
    wdata           = BLANK_CELL;
    raddr           = '0;
    q_pop           = 1'b0;
    col_n           = XW'(col);
    row_inc         = 1'b0;
    load_out        = 1'b0;

    case (state)
      S_INIT, S_CLEAR: begin
        we        = 1'b1;
        sidx_next = sidx + 1'b1;
        if (sidx == LAST_CELL) begin
          sidx_next  = '0;
          state_next = (state == S_INIT) ? S_IDLE : S_RESP;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop           = 1'b1;
          res_data_next   = '0;
          res_scroll_next = 1'b0;
          state_next      = S_RESP;
          case (q_data.op)
            OP_PRINT: begin
              we    = 1'b1;
              waddr = pos;
              wdata = {attr, q_data.ch};
              col_n = XW'(col) + XW'(1);
            end
            OP_BS: begin
              if (col != '0) col_n = XW'(col) - XW'(1);
            end
            OP_TAB: col_n = tab_tbl[col];
            OP_CR:  col_n = '0;
            OP_LF: begin
              col_n   = '0;
              row_inc = 1'b1;
            end
            OP_CLEAR: begin
              col_n      = '0;
              row_next   = '0;
              sidx_next  = '0;
              state_next = S_CLEAR;
            end
            OP_READ: begin
              raddr = idx_addr;
              if (idx_ok) state_next = S_RDATA;
            end
            default: ;
          endcase
          if (col_n >= XW'(COLUMNS)) begin
            col_n   = '0;
            row_inc = 1'b1;
          end
          col_next = CW'(col_n);
          if (row_inc) begin
            if (row == ROW_LAST) begin
              state_next      = S_SCROLL;
              sidx_next       = '0;
              res_scroll_next = 1'b1;
            end else begin
              row_next = row + 1'b1;
            end
          end
        end
      end
      S_RDATA: begin
        res_data_next = rdata;
        state_next    = S_RESP;
      end
      S_SCROLL: begin
        if (sidx < SHIFT_END) raddr = sidx + COLS_A;
        sidx_next = sidx + 1'b1;
        if (sidx == LAST_CELL) begin
          sidx_next  = '0;
          state_next = S_SDRAIN;
        end
      end
      S_SDRAIN: state_next = S_RESP;
      S_RESP: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (wp_valid) begin
      we    = 1'b1;
      waddr = wp_addr;
      wdata = wp_blank ? BLANK_CELL : rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      sidx     <= '0;
      col      <= '0;
      row      <= '0;
      wp_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      sidx     <= sidx_next;
      col      <= col_next;
      row      <= row_next;
      wp_valid <= (state == S_SCROLL);
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_data   <= res_data_next;
    res_scroll <= res_scroll_next;
    wp_addr    <= sidx;
    wp_blank   <= (sidx >= SHIFT_END);
    if (load_out) begin
      out_pos  <= POS_W'(pos);
      out_data <= res_data;
      out_scr  <= res_scroll;
    end
  end

  assign m_tdata = {4'b0, out_scr, out_data, out_pos};

endmodule

/* tb/tb_text_console_char_writer_top.sv */
// Self-checking testbench for the text console character writer: stream, APB and scoreboard.
`timescale 1ns / 1ps

module tb_text_console_char_writer_top
  import tcc_pkg::*;
();

  localparam int COLS  = COLUMNS_DEF;
  localparam int ROWS  = ROWS_DEF;
  localparam int TABW  = TAB_WIDTH_DEF;
  localparam int CELLS = COLS * ROWS;
  localparam int ITEMS_PER_PHASE = 119;
  localparam int PHASES = 8;
  localparam int CYCLE_LIMIT = 10000000;
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } console_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] read_data;
    logic              scrolled;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [7:0] char_code, [18:8] cell_index
  logic [1:0]  s_tuser = '0;   // [1:0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [10:0] cursor_pos, [26:11] read_data, [27] scrolled
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  text_console_char_writer_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // screen and cursor as the block should hold them
  logic [DATA_W-1:0] screen_model [CELLS];
  logic [6:0]        cur_col;
  logic [4:0]        cur_row;
  logic [ATTR_W-1:0] text_attr;

  console_req_t    console_requests[$];
  console_result_t predicted_replies[$];
  console_req_t    inflight_req;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              fail_count = 0;
  int              cycle_count = 0;

  function automatic console_result_t apply_console_request(console_req_t r);
    console_result_t res;
    int c;
    int rw;
    res = '0;
    c = int'(cur_col);
    rw = int'(cur_row);
    case (r.func)
      FUNC_PUT: begin
        if (r.ch == CH_BS) begin
          if (c > 0) c--;
        end else if (r.ch == CH_TAB) begin
          c = c + TABW - c % TABW;
        end else if (r.ch == CH_CR) begin
          c = 0;
        end else if (r.ch == CH_LF) begin
          c = 0;
          rw++;
        end else if (r.ch >= PRINT_LO && r.ch <= PRINT_HI) begin
          screen_model[rw * COLS + c] = {text_attr, r.ch};
          c++;
        end
        if (c >= COLS) begin
          c = 0;
          rw++;
        end
        if (rw >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_model[i] = screen_model[i + COLS];
          for (int i = (ROWS - 1) * COLS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
          rw = ROWS - 1;
          res.scrolled = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
        c = 0;
        rw = 0;
      end
      FUNC_READ: begin
        if (r.idx < CELLS) res.read_data = screen_model[r.idx];
      end
      default: ;
    endcase
    cur_col = 7'(c);
    cur_row = 5'(rw);
    res.pos = POS_W'(rw * COLS + c);
    return res;
  endfunction

  // mostly puts; rare clears so the cursor gets to the bottom and scrolls
  function automatic console_req_t random_console_request();
    console_req_t r;
    int pick;
    int sel;
    r.func = FUNC_PUT;
    r.ch = CHAR_W'($urandom_range(0, 255));
    r.idx = IDX_W'($urandom_range(0, 2047));
    pick = $urandom_range(0, 999);
    if (pick < 3) begin
      r.func = FUNC_CLEAR;
    end else if (pick < 160) begin
      r.func = FUNC_READ;
      if ($urandom_range(0, 3) != 0) r.idx = IDX_W'($urandom_range(0, CELLS - 1));
    end else if (pick < 185) begin
      r.func = FUNC_NOP;
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 55) r.ch = CHAR_W'($urandom_range(PRINT_LO, PRINT_HI));
      else if (sel < 65) r.ch = CH_TAB;
      else if (sel < 77) r.ch = CH_LF;
      else if (sel < 83) r.ch = CH_CR;
      else if (sel < 91) r.ch = CH_BS;
    end
    return r;
  endfunction

  function automatic void push_request(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                                       logic [IDX_W-1:0] idx);
    console_req_t r;
    r.func = func;
    r.ch = ch;
    r.idx = idx;
    console_requests.push_back(r);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predicted_replies.push_back(apply_console_request(inflight_req));
      if (!s_tvalid || s_tready) begin
        if (console_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          inflight_req = console_requests.pop_front();
          s_tuser <= inflight_req.func;
          s_tdata <= {5'b0, inflight_req.idx, inflight_req.ch};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and scoreboard
  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (predicted_replies.size() == 0) begin
          $error("result with no request outstanding: tdata %h", m_tdata);
          fail_count++;
        end else begin
          want = predicted_replies.pop_front();
          if (m_tdata[10:0] !== want.pos) begin
            $error("cursor_pos mismatch: expected %0d, actual %0d", want.pos, m_tdata[10:0]);
            fail_count++;
          end
          if (m_tdata[26:11] !== want.read_data) begin
            $error("read_data mismatch: expected %h, actual %h", want.read_data,
                   m_tdata[26:11]);
            fail_count++;
          end
          if (m_tdata[27] !== want.scrolled) begin
            $error("scrolled mismatch: expected %0d, actual %0d", want.scrolled, m_tdata[27]);
            fail_count++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (console_requests.size() != 0 || s_tvalid || predicted_replies.size() != 0);
  endtask

  // setup and access cycle; the register takes the value at the access edge
  task automatic write_text_attribute(input logic [ATTR_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_ATTR;
    pwdata <= {24'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    text_attr = value;
  endtask

  initial begin : stimulus
    logic [ATTR_W-1:0] phase_attr [PHASES];
    phase_attr = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h80, 8'h01, 8'h7F, 8'h0F};
    for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
    cur_col = '0;
    cur_row = '0;
    text_attr = ATTR_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: blank reads, print range edges, ignored bytes, cursor moves
    @(negedge clk);
    push_request(FUNC_READ, 8'h00, 11'd0);
    push_request(FUNC_READ, 8'h00, 11'd1999);
    push_request(FUNC_READ, 8'h00, 11'd2000);
    push_request(FUNC_READ, 8'hFF, 11'd2047);
    push_request(FUNC_PUT, 8'h41, 11'd0);
    push_request(FUNC_PUT, PRINT_LO, 11'd0);
    push_request(FUNC_PUT, PRINT_HI, 11'd0);
    push_request(FUNC_PUT, 8'h1F, 11'd0);
    push_request(FUNC_PUT, 8'h80, 11'd0);
    push_request(FUNC_PUT, 8'hFF, 11'd0);
    push_request(FUNC_PUT, 8'h00, 11'd0);
    push_request(FUNC_PUT, CH_BS, 11'd0);
    push_request(FUNC_PUT, CH_TAB, 11'd0);
    push_request(FUNC_PUT, CH_CR, 11'd0);
    push_request(FUNC_PUT, CH_BS, 11'd0);
    push_request(FUNC_PUT, CH_LF, 11'd0);
    push_request(FUNC_NOP, 8'hFF, 11'h7FF);
    push_request(FUNC_READ, 8'h00, 11'd0);
    push_request(FUNC_READ, 8'h00, 11'd2);
    push_request(FUNC_CLEAR, 8'h00, 11'd0);
    push_request(FUNC_READ, 8'h00, 11'd0);
    push_request(FUNC_PUT, 8'h55, 11'd0);
    push_request(FUNC_READ, 8'h00, 11'd0);
    push_request(FUNC_NOP, 8'h00, 11'd0);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph % 3 == 2) write_text_attribute(ATTR_W'($urandom_range(0, 255)));
      else write_text_attribute(phase_attr[ph]);
      @(negedge clk);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) console_requests.push_back(random_console_request());
      wait_drained();
    end

    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/tcc_pkg.sv
src/tcc_front.sv
src/tcc_queue.sv
src/tcc_back.sv
src/text_console_char_writer_top.sv
tb/tb_text_console_char_writer_top.sv
